// File: rtl/ray_sphere_occlusion_test_assert.svh
// assertion macros shared by the ray-sphere occlusion test modules
`ifndef RAY_SPHERE_OCCLUSION_TEST_ASSERT_SVH
`define RAY_SPHERE_OCCLUSION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define RSO_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rso assertion failed");
`define RSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rso assertion failed");
`else
`define RSO_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define RSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/rso_pkg.sv
// types, constants and helpers of the ray-sphere occlusion test
package rso_pkg;

  // transaction kinds
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT  = 3'd5;

  // one world unit in Q24.8
  localparam int unsigned UNIT = 256;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [23:0]        world_scale;
    logic               occlude_enable;
    logic [4:0]         body_count;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        body_radius;
    logic [4:0]         exclude_index;
  } item_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        size;
  } body_t;

  // clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/rso_front.sv
// front end: takes transactions, decodes the kind and queues them for the back end
module rso_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          push_operation,
  input  logic [3:0]    push_body_index,
  input  logic [31:0]   push_pos_x,
  input  logic [31:0]   push_pos_y,
  input  logic [31:0]   push_pos_z,
  input  logic [30:0]   push_body_radius,
  input  logic [4:0]    push_exclude_index,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rso_pkg::item_t head
);

  rso_pkg::item_t                 queue_mem [rso_pkg::QUEUE_DEPTH];
  logic [rso_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rso_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rso_pkg::QCNT_W-1:0]     count_r, count_nxt;
  rso_pkg::item_t                 item_in;

  // decode the transaction into a queue entry
  always_comb begin
    item_in.op            = push_operation ? rso_pkg::OP_QUERY : rso_pkg::OP_LOAD;
    item_in.body_index    = push_body_index;
    item_in.pos_x         = $signed(push_pos_x);
    item_in.pos_y         = $signed(push_pos_y);
    item_in.pos_z         = $signed(push_pos_z);
    item_in.body_radius   = push_body_radius;
    item_in.exclude_index = push_exclude_index;
  end

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr_r] <= item_in;
    end
  end

  assign head  = queue_mem[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == rso_pkg::QCNT_W'(rso_pkg::QUEUE_DEPTH));

`include "ray_sphere_occlusion_test_assert.svh"

  `RSO_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push && !pop, !full)
  `RSO_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1,
                      count_r <= rso_pkg::QCNT_W'(rso_pkg::QUEUE_DEPTH))

endmodule

// File: rtl/rso_isqrt.sv
// iterative integer square root, one root bit per cycle
module rso_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // one digit step
  always_comb begin
    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/rso_div.sv
// iterative restoring divider for the direction components, one quotient bit per cycle
module rso_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [30:0] quotient
);

  // quotient fits 31 bits because the dividend top half stays below the divisor
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] low_r, low_nxt;
  logic [30:0] quot_r, quot_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;

  always_comb begin
    rem_sh   = {rem_r, low_r[30]};
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend[61:31]};
      low_nxt  = dividend[30:0];
      quot_nxt = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 5'd31;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      low_nxt = {low_r[29:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt  = 32'(rem_sh - {1'b0, dvs_r});
        quot_nxt = {quot_r[29:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[31:0];
        quot_nxt = {quot_r[29:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// File: rtl/rso_back.sv
// back end: body table, shared multiplier and the query sequencer
module rso_back #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rso_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  rso_pkg::item_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  output logic           out_occluded
);

  localparam int unsigned IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BODIES + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DELTA  = 13'b0000000000010,
    ST_MUL    = 13'b0000000000100,
    ST_TAKE   = 13'b0000000001000,
    ST_LEN    = 13'b0000000010000,
    ST_DSTART = 13'b0000000100000,
    ST_DIV    = 13'b0000001000000,
    ST_NEXT   = 13'b0000010000000,
    ST_BMAG   = 13'b0000100000000,
    ST_DISC   = 13'b0001000000000,
    ST_ROOT   = 13'b0010000000000,
    ST_HIT    = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  // multiplier operation sequence
  typedef enum logic [3:0] {
    M_DX2, M_DY2, M_DZ2, M_RAD, M_CX, M_CY, M_CZ,
    M_MX2, M_MY2, M_MZ2, M_DTX, M_DTY, M_DTZ, M_B2, M_R2
  } msel_t;

  typedef enum logic [1:0] {
    AX_X, AX_Y, AX_Z
  } axis_t;

  state_t                 state_r, state_nxt;
  msel_t                  msel_r, msel_nxt;
  axis_t                  axis_r, axis_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_occ_r, out_occ_nxt;

  logic signed [31:0]     px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [4:0]             excl_r, excl_nxt;
  logic signed [31:0]     dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [31:0]            len_r, len_nxt;
  logic signed [31:0]     ux_r, ux_nxt, uy_r, uy_nxt, uz_r, uz_nxt;
  logic [30:0]            r_r, r_nxt;
  logic signed [31:0]     mx_r, mx_nxt, my_r, my_nxt, mz_r, mz_nxt;
  logic signed [63:0]     dot_r, dot_nxt;
  logic [31:0]            bmag_r, bmag_nxt;
  logic                   bneg_r, bneg_nxt;
  logic signed [65:0]     diff_r, diff_nxt;
  logic signed [65:0]     s_r, s_nxt;
  logic [31:0]            sq_r, sq_nxt;
  logic signed [65:0]     prod_r;

  rso_pkg::body_t         body_mem [MAX_BODIES];
  rso_pkg::body_t         rd_r;
  logic                   mem_we, mem_re;

  logic signed [32:0]     mul_a, mul_b;
  logic signed [65:0]     mul_p;
  logic                   sq_start, sq_busy, sq_done;
  logic [63:0]            sq_in;
  logic [31:0]            sq_root;
  logic                   div_start, div_busy, div_done;
  logic [61:0]            div_in;
  logic [30:0]            div_q;

  logic [CMP_W-1:0]       n_eff;
  logic signed [31:0]     d_sel;
  logic [31:0]            d_mag;
  logic signed [31:0]     q_signed;
  logic signed [65:0]     rs_wide;
  logic signed [31:0]     scaled;
  logic signed [31:0]     cam_sel;
  logic signed [31:0]     m_new;
  logic signed [63:0]     dot_abs;
  logic [33:0]            b_shift;
  logic signed [34:0]     b_s, nb, sq35, t0, t1, lim;
  logic                   hit;

  // iterative units
  rso_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  rso_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (len_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // tested entry count, clamped to the table depth
  always_comb begin
    if (CMP_W'(cfg.body_count) > CMP_W'(MAX_BODIES)) begin
      n_eff = CMP_W'(MAX_BODIES);
    end else begin
      n_eff = CMP_W'(cfg.body_count);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (msel_r)
      M_DX2: begin mul_a = 33'(dx_r); mul_b = 33'(dx_r); end
      M_DY2: begin mul_a = 33'(dy_r); mul_b = 33'(dy_r); end
      M_DZ2: begin mul_a = 33'(dz_r); mul_b = 33'(dz_r); end
      M_RAD: begin
        mul_a = $signed({2'b00, rd_r.size});
        mul_b = $signed({9'd0, cfg.world_scale});
      end
      M_CX: begin mul_a = 33'($signed(rd_r.cx)); mul_b = $signed({9'd0, cfg.world_scale}); end
      M_CY: begin mul_a = 33'($signed(rd_r.cy)); mul_b = $signed({9'd0, cfg.world_scale}); end
      M_CZ: begin mul_a = 33'($signed(rd_r.cz)); mul_b = $signed({9'd0, cfg.world_scale}); end
      M_MX2: begin mul_a = 33'(mx_r); mul_b = 33'(mx_r); end
      M_MY2: begin mul_a = 33'(my_r); mul_b = 33'(my_r); end
      M_MZ2: begin mul_a = 33'(mz_r); mul_b = 33'(mz_r); end
      M_DTX: begin mul_a = 33'(mx_r); mul_b = 33'(ux_r); end
      M_DTY: begin mul_a = 33'(my_r); mul_b = 33'(uy_r); end
      M_DTZ: begin mul_a = 33'(mz_r); mul_b = 33'(uz_r); end
      M_B2:  begin mul_a = $signed({1'b0, bmag_r}); mul_b = $signed({1'b0, bmag_r}); end
      M_R2:  begin mul_a = $signed({2'b00, r_r}); mul_b = $signed({2'b00, r_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // datapath helpers
  always_comb begin
    case (axis_r)
      AX_X:    d_sel = dx_r;
      AX_Y:    d_sel = dy_r;
      default: d_sel = dz_r;
    endcase
    d_mag    = d_sel[31] ? (~d_sel + 32'd1) : d_sel;
    div_in   = {d_mag, 30'd0};
    q_signed = d_sel[31] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    rs_wide = prod_r >>> 16;
    scaled  = rso_pkg::sat32(rs_wide);
    case (msel_r)
      M_CX:    cam_sel = cfg.cam_x;
      M_CY:    cam_sel = cfg.cam_y;
      default: cam_sel = cfg.cam_z;
    endcase
    m_new = rso_pkg::sat32(66'(cam_sel) - 66'(scaled));

    dot_abs = dot_r[63] ? -dot_r : dot_r;
    b_shift = dot_abs[63:30];

    b_s  = bneg_r ? -$signed({3'b000, bmag_r}) : $signed({3'b000, bmag_r});
    nb   = -b_s;
    sq35 = $signed({3'b000, sq_r});
    t0   = nb - sq35;
    t1   = nb + sq35;
    lim  = $signed({3'b000, len_r}) - $signed(35'(rso_pkg::UNIT));
    hit  = ((t0 > $signed(35'(rso_pkg::UNIT))) && (t0 < lim)) ||
           ((t1 > $signed(35'(rso_pkg::UNIT))) && (t1 < lim));
  end

  // query sequencer
  always_comb begin
    state_nxt     = state_r;
    msel_nxt      = msel_r;
    axis_nxt      = axis_r;
    i_nxt         = i_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_occ_nxt   = out_occ_r;
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    excl_nxt = excl_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    acc_nxt = acc_r;
    len_nxt = len_r;
    ux_nxt = ux_r; uy_nxt = uy_r; uz_nxt = uz_r;
    r_nxt = r_r;
    mx_nxt = mx_r; my_nxt = my_r; mz_nxt = mz_r;
    dot_nxt  = dot_r;
    bmag_nxt = bmag_r;
    bneg_nxt = bneg_r;
    diff_nxt = diff_r;
    s_nxt    = s_r;
    sq_nxt   = sq_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    sq_start  = 1'b0;
    sq_in     = acc_r;
    div_start = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == rso_pkg::OP_LOAD) begin
            mem_we = (CMP_W'(q_head.body_index) < CMP_W'(MAX_BODIES));
          end else begin
            px_nxt   = q_head.pos_x;
            py_nxt   = q_head.pos_y;
            pz_nxt   = q_head.pos_z;
            excl_nxt = q_head.exclude_index;
            if (!cfg.occlude_enable) begin
              res_nxt   = 1'b0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DELTA;
            end
          end
        end
      end
      ST_DELTA: begin
        dx_nxt    = rso_pkg::sat32(66'(px_r) - 66'(cfg.cam_x));
        dy_nxt    = rso_pkg::sat32(66'(py_r) - 66'(cfg.cam_y));
        dz_nxt    = rso_pkg::sat32(66'(pz_r) - 66'(cfg.cam_z));
        msel_nxt  = M_DX2;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        state_nxt = ST_MUL;
        unique case (msel_r)
          M_DX2: begin acc_nxt = prod_r[63:0]; msel_nxt = M_DY2; end
          M_DY2: begin acc_nxt = acc_r + prod_r[63:0]; msel_nxt = M_DZ2; end
          M_DZ2: begin
            sq_start  = 1'b1;
            sq_in     = acc_r + prod_r[63:0];
            state_nxt = ST_LEN;
          end
          M_RAD: begin
            r_nxt = (|prod_r[65:47]) ? 31'h7FFF_FFFF : prod_r[46:16];
            if (prod_r[65:16] == '0) begin
              i_nxt     = i_r + 1'b1;
              state_nxt = ST_NEXT;
            end else begin
              msel_nxt = M_CX;
            end
          end
          M_CX: begin mx_nxt = m_new; msel_nxt = M_CY; end
          M_CY: begin my_nxt = m_new; msel_nxt = M_CZ; end
          M_CZ: begin mz_nxt = m_new; msel_nxt = M_MX2; end
          M_MX2: begin acc_nxt = prod_r[63:0]; msel_nxt = M_MY2; end
          M_MY2: begin acc_nxt = acc_r + prod_r[63:0]; msel_nxt = M_MZ2; end
          M_MZ2: begin acc_nxt = acc_r + prod_r[63:0]; msel_nxt = M_DTX; end
          M_DTX: begin dot_nxt = prod_r[63:0]; msel_nxt = M_DTY; end
          M_DTY: begin dot_nxt = dot_r + prod_r[63:0]; msel_nxt = M_DTZ; end
          M_DTZ: begin
            dot_nxt   = dot_r + prod_r[63:0];
            state_nxt = ST_BMAG;
          end
          M_B2: begin
            diff_nxt = $signed(66'(prod_r[63:0])) - $signed(66'(acc_r));
            msel_nxt = M_R2;
          end
          M_R2: begin
            s_nxt     = $signed(66'(prod_r[63:0])) + diff_r;
            state_nxt = ST_DISC;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_LEN: begin
        if (sq_done) begin
          len_nxt = sq_root;
          if (sq_root < 32'(rso_pkg::UNIT)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            axis_nxt  = AX_X;
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          case (axis_r)
            AX_X: begin ux_nxt = q_signed; axis_nxt = AX_Y; state_nxt = ST_DSTART; end
            AX_Y: begin uy_nxt = q_signed; axis_nxt = AX_Z; state_nxt = ST_DSTART; end
            default: begin
              uz_nxt    = q_signed;
              i_nxt     = '0;
              state_nxt = ST_NEXT;
            end
          endcase
        end
      end
      ST_NEXT: begin
        if (CMP_W'(i_r) >= n_eff) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else if (CMP_W'(i_r) == CMP_W'(excl_r)) begin
          i_nxt = i_r + 1'b1;
        end else begin
          mem_re    = 1'b1;
          msel_nxt  = M_RAD;
          state_nxt = ST_MUL;
        end
      end
      ST_BMAG: begin
        bmag_nxt  = (|b_shift[33:32]) ? 32'hFFFF_FFFF : b_shift[31:0];
        bneg_nxt  = dot_r[63];
        msel_nxt  = M_B2;
        state_nxt = ST_MUL;
      end
      ST_DISC: begin
        if (s_r[65]) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_NEXT;
        end else begin
          sq_start  = 1'b1;
          sq_in     = (|s_r[64]) ? 64'hFFFF_FFFF_FFFF_FFFF : s_r[63:0];
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          sq_nxt    = sq_root;
          state_nxt = ST_HIT;
        end
      end
      ST_HIT: begin
        if (hit) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_occ_nxt   = res_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      msel_r      <= M_DX2;
      axis_r      <= AX_X;
      i_r         <= '0;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      msel_r      <= msel_nxt;
      axis_r      <= axis_nxt;
      i_r         <= i_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_occ_r <= out_occ_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
    excl_r <= excl_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    acc_r <= acc_nxt;
    len_r <= len_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt; uz_r <= uz_nxt;
    r_r <= r_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; mz_r <= mz_nxt;
    dot_r  <= dot_nxt;
    bmag_r <= bmag_nxt;
    bneg_r <= bneg_nxt;
    diff_r <= diff_nxt;
    s_r    <= s_nxt;
    sq_r   <= sq_nxt;
    prod_r <= mul_p;
  end

  // body table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      body_mem[IDX_W'(q_head.body_index)] <= '{cx:   q_head.pos_x,
                                               cy:   q_head.pos_y,
                                               cz:   q_head.pos_z,
                                               size: q_head.body_radius};
    end
    if (mem_re) begin
      rd_r <= body_mem[i_r[IDX_W-1:0]];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_occluded = out_occ_r;

`include "ray_sphere_occlusion_test_assert.svh"

  `RSO_ASSERT_IMPLIES(a_div_start_idle, clk, rst_n, div_start, !div_busy)
  `RSO_ASSERT_IMPLIES(a_sqrt_start_idle, clk, rst_n, sq_start, !sq_busy)
  `RSO_ASSERT_NEXT(a_result_after_done, clk, rst_n, state_r == ST_DONE, out_valid_r)
  `RSO_ASSERT_IMPLIES(a_pop_when_idle, clk, rst_n, q_pop, state_r == ST_IDLE && !q_empty)

endmodule

// File: rtl/ray_sphere_occlusion_test.sv
// top level of the ray-sphere occlusion test: configuration registers, front and back
//
// Usage:
//   Input channel: a transaction is taken on a rising edge with start high and busy low.
//   in_operation 0 loads body entry in_body_index (center in_pos_*, radius in_body_radius);
//   1 queries point in_pos_* and skips body in_exclude_index.
//   Loads give no result. Each query gives one result: out_valid is high for exactly one
//   cycle with out_occluded; the receiver cannot hold it off.
//   Configuration: cfg_we writes cfg_data to register cfg_index in the same edge
//   (0..2 camera x/y/z, 3 world scale, 4 occlusion enable, 5 body count); write only when idle.
//   A two-entry queue sits between the front end and the back end; busy is high while it
//   is full. Transactions are processed one at a time by the back end.
//   A load writes its body table entry from the queue head. A query first runs one
//   32-step square root for the segment length and three 31-step divisions for the
//   direction, then tests each body in turn with the shared 33x33 multiplier (each
//   product registered before use) and the 32-step square root of the discriminant; it
//   stops at the first hit. Disabled occlusion answers without testing any body.
//   Reset (rst_n low, synchronous) clears the queue and the sequencer and loads the
//   register defaults; the body table holds no defined contents until loaded.
module ray_sphere_occlusion_test #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [3:0]  in_body_index,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [30:0] in_body_radius,
  input  logic [4:0]  in_exclude_index,
  output logic        out_valid,
  output logic        out_occluded,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [23:0]        world_scale_r;
  logic               occ_en_r;
  logic [4:0]         body_count_r;
  rso_pkg::cfg_t      cfg;
  rso_pkg::item_t     q_head;
  logic               q_full, q_empty, q_pop, push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r       <= '0;
      cam_y_r       <= '0;
      cam_z_r       <= '0;
      world_scale_r <= 24'd65536;
      occ_en_r      <= 1'b1;
      body_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rso_pkg::CFG_CAM_X:       cam_x_r       <= cfg_data;
        rso_pkg::CFG_CAM_Y:       cam_y_r       <= cfg_data;
        rso_pkg::CFG_CAM_Z:       cam_z_r       <= cfg_data;
        rso_pkg::CFG_WORLD_SCALE: world_scale_r <= cfg_data[23:0];
        rso_pkg::CFG_OCC_ENABLE:  occ_en_r      <= cfg_data[0];
        rso_pkg::CFG_BODY_COUNT:  body_count_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cam_x          = cam_x_r;
    cfg.cam_y          = cam_y_r;
    cfg.cam_z          = cam_z_r;
    cfg.world_scale    = world_scale_r;
    cfg.occlude_enable = occ_en_r;
    cfg.body_count     = body_count_r;
  end

  // input handshake
  assign busy = q_full;
  assign push = start && !q_full;

  rso_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .push_operation     (in_operation),
    .push_body_index    (in_body_index),
    .push_pos_x         (in_pos_x),
    .push_pos_y         (in_pos_y),
    .push_pos_z         (in_pos_z),
    .push_body_radius   (in_body_radius),
    .push_exclude_index (in_exclude_index),
    .full               (q_full),
    .pop                (q_pop),
    .empty              (q_empty),
    .head               (q_head)
  );

  rso_back #(
    .MAX_BODIES (MAX_BODIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_occluded (out_occluded)
  );

endmodule
